@@ hdl/dma_stream_controller_core_macros.svh @@
// Assertion macros shared by the DMA stream controller RTL
`ifndef DMA_STREAM_CONTROLLER_CORE_MACROS_SVH
`define DMA_STREAM_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dsc assertion failed");
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsc assertion failed");
`else
`define DSC_ASSERT(lbl, clk, rst_n, prop)
`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/dsc_pkg.sv @@
// Types, register map constants and helper functions of the DMA stream controller
`timescale 1ns / 1ps
package dsc_pkg;

    localparam int NUM_STREAMS_DEF = 8;
    localparam int STREAMS_PER_REG = 4;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_BYTE  = 2'd2
    } dsc_kind_e;

    typedef enum logic [2:0] {
        REG_CR   = 3'd0,
        REG_NDTR = 3'd1,
        REG_PAR  = 3'd2,
        REG_M0AR = 3'd3,
        REG_M1AR = 3'd4,
        REG_FCR  = 3'd5
    } dsc_reg_e;

    localparam int NUM_STREAM_REGS = 6;

    localparam logic [9:0] OFF_LISR  = 10'h000;
    localparam logic [9:0] OFF_HISR  = 10'h004;
    localparam logic [9:0] OFF_LIFCR = 10'h008;
    localparam logic [9:0] OFF_HIFCR = 10'h00C;
    localparam int STREAM_BASE   = 16;
    localparam int STREAM_STRIDE = 24;

    // control register bits
    localparam int CR_EN    = 0;
    localparam int CR_DMEIE = 1;
    localparam int CR_TEIE  = 2;
    localparam int CR_HTIE  = 3;
    localparam int CR_TCIE  = 4;
    localparam int CR_DIR_LSB = 6;
    localparam int CR_CIRC  = 8;
    localparam int CR_PINC  = 9;
    localparam int CR_MINC  = 10;
    localparam int CR_DBM   = 18;
    localparam int CR_CT    = 19;

    localparam logic [1:0] DIR_P2M = 2'b00;
    localparam logic [1:0] DIR_M2P = 2'b01;

    // flag bits within a stream's 6-bit group
    localparam int FL_DMEIF = 2;
    localparam int FL_TEIF  = 3;
    localparam int FL_HTIF  = 4;
    localparam int FL_TCIF  = 5;
    localparam logic [5:0] FLAG_MASK = 6'h3F;

    localparam logic [31:0] FCR_RESET = 32'h0000_0021;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] wdata;
        logic [31:0] paddr;
        logic [7:0]  bval;
    } dsc_req_t;

    typedef struct packed {
        logic     is_lisr;
        logic     is_hisr;
        logic     is_lifcr;
        logic     is_hifcr;
        logic     stream_hit;
        dsc_reg_e reg_sel;
    } dsc_dec_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        byte_taken;
        logic        mem_write_valid;
        logic [31:0] mem_write_addr;
        logic [7:0]  mem_write_byte;
        logic        copy_valid;
        logic [31:0] copy_src;
        logic [31:0] copy_dst;
        logic [15:0] copy_count;
        logic        copy_src_inc;
        logic        copy_dst_inc;
    } dsc_result_t;

    // bit position of a stream's flag group inside LISR/HISR: 0, 6, 16, 22
    function automatic logic [4:0] dsc_flag_shift(input logic [1:0] grp);
        return {grp[1], 4'b0000} | (grp[0] ? 5'd6 : 5'd0);
    endfunction

    function automatic logic dsc_irq_up(input logic [5:0] fl, input logic [31:0] cr);
        return (cr[CR_TCIE] & fl[FL_TCIF]) | (cr[CR_HTIE] & fl[FL_HTIF]) |
               (cr[CR_TEIE] & fl[FL_TEIF]) | (cr[CR_DMEIE] & fl[FL_DMEIF]);
    endfunction

endpackage

@@ hdl/dsc_decode.sv @@
// Bus offset decoder for the DMA stream controller register map
`timescale 1ns / 1ps
module dsc_decode
    import dsc_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF,
    localparam int IDX_W = $clog2(NUM_STREAMS)
) (
    input  logic [9:0]       offset,
    output dsc_dec_t         dec,
    output logic [IDX_W-1:0] idx
);

    always_comb begin
        dec            = '0;
        dec.reg_sel    = REG_CR;
        idx            = '0;
        dec.is_lisr    = (offset == OFF_LISR);
        dec.is_hisr    = (offset == OFF_HISR);
        dec.is_lifcr   = (offset == OFF_LIFCR);
        dec.is_hifcr   = (offset == OFF_HIFCR);
        // unaligned or out-of-range offsets match nothing
        for (int n = 0; n < NUM_STREAMS; n++) begin
            for (int r = 0; r < NUM_STREAM_REGS; r++) begin
                if (offset == 10'(STREAM_BASE + STREAM_STRIDE * n + 4 * r)) begin
                    dec.stream_hit = 1'b1;
                    dec.reg_sel    = dsc_reg_e'(3'(r));
                    idx            = IDX_W'(n);
                end
            end
        end
    end

endmodule

@@ hdl/dsc_core.sv @@
// Stream register file, byte claim logic and per-request state update
`timescale 1ns / 1ps
`include "dma_stream_controller_core_macros.svh"
module dsc_core
    import dsc_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF,
    localparam int IDX_W = $clog2(NUM_STREAMS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  dsc_req_t               req,
    input  dsc_dec_t               dec,
    input  logic [IDX_W-1:0]       idx,
    output dsc_result_t            res,
    output logic [NUM_STREAMS-1:0] irq_next
);

    logic [31:0] ctrl_reg  [NUM_STREAMS];
    logic [15:0] cnt_reg   [NUM_STREAMS];
    logic [15:0] start_reg [NUM_STREAMS];
    logic [31:0] par_reg   [NUM_STREAMS];
    logic [31:0] m0_reg    [NUM_STREAMS];
    logic [31:0] m1_reg    [NUM_STREAMS];
    logic [31:0] fcr_reg   [NUM_STREAMS];
    logic [31:0] ctrl_next  [NUM_STREAMS];
    logic [15:0] cnt_next   [NUM_STREAMS];
    logic [15:0] start_next [NUM_STREAMS];
    logic [31:0] par_next   [NUM_STREAMS];
    logic [31:0] m0_next    [NUM_STREAMS];
    logic [31:0] m1_next    [NUM_STREAMS];
    logic [31:0] fcr_next   [NUM_STREAMS];
    logic [31:0] low_reg, low_next;
    logic [31:0] high_reg, high_next;
    logic [NUM_STREAMS-1:0] irq_reg;

    logic                   is_rd, is_wr, is_byte;
    logic [NUM_STREAMS-1:0] cand, grant, tc_set, copy_set, refresh;
    logic [31:0]            lane_addr [NUM_STREAMS];
    logic [31:0]            low_set, high_set;

    assign is_rd   = adv && (req.kind == REQ_READ);
    assign is_wr   = adv && (req.kind == REQ_WRITE);
    assign is_byte = adv && (req.kind == REQ_BYTE);

    // claim candidates and their memory addresses, one lane per stream
    always_comb begin
        for (int n = 0; n < NUM_STREAMS; n++) begin
            cand[n] = ctrl_reg[n][CR_EN] &&
                      (ctrl_reg[n][CR_DIR_LSB+:2] == DIR_P2M) &&
                      (par_reg[n] == req.paddr) && (cnt_reg[n] != '0);
            lane_addr[n] = ((ctrl_reg[n][CR_DBM] && ctrl_reg[n][CR_CT]) ? m1_reg[n] : m0_reg[n])
                         + ({16'h0000, start_reg[n]} - {16'h0000, cnt_reg[n]});
        end
    end

    // lowest-numbered candidate wins
    assign grant = is_byte ? (cand & (~cand + NUM_STREAMS'(1))) : '0;

    always_comb begin
        logic wr_n;
        for (int n = 0; n < NUM_STREAMS; n++) begin
            ctrl_next[n]  = ctrl_reg[n];
            cnt_next[n]   = cnt_reg[n];
            start_next[n] = start_reg[n];
            par_next[n]   = par_reg[n];
            m0_next[n]    = m0_reg[n];
            m1_next[n]    = m1_reg[n];
            fcr_next[n]   = fcr_reg[n];
            tc_set[n]     = 1'b0;
            copy_set[n]   = 1'b0;
            wr_n = is_wr && dec.stream_hit && (idx == IDX_W'(n));
            if (wr_n) begin
                case (dec.reg_sel)
                    REG_CR: begin
                        ctrl_next[n] = req.wdata;
                        if (!ctrl_reg[n][CR_EN] && req.wdata[CR_EN]) begin
                            start_next[n] = cnt_reg[n];
                            // normal mode: the whole block goes out as one copy request
                            if (!req.wdata[CR_CIRC] && !req.wdata[CR_DBM] &&
                                (cnt_reg[n] != '0)) begin
                                copy_set[n]         = 1'b1;
                                tc_set[n]           = 1'b1;
                                ctrl_next[n][CR_EN] = 1'b0;
                                cnt_next[n]         = '0;
                            end
                        end
                    end
                    REG_NDTR: cnt_next[n] = req.wdata[15:0];
                    REG_PAR:  par_next[n] = req.wdata;
                    REG_M0AR: m0_next[n]  = req.wdata;
                    REG_M1AR: m1_next[n]  = req.wdata;
                    REG_FCR:  fcr_next[n] = req.wdata;
                    default: ;
                endcase
            end
            if (grant[n]) begin
                cnt_next[n] = cnt_reg[n] - 16'd1;
                if (cnt_reg[n] == 16'd1) begin
                    tc_set[n] = 1'b1;
                    if (ctrl_reg[n][CR_DBM]) begin
                        ctrl_next[n][CR_CT] = ~ctrl_reg[n][CR_CT];
                        cnt_next[n]         = start_reg[n];
                    end else if (ctrl_reg[n][CR_CIRC]) begin
                        cnt_next[n] = start_reg[n];
                    end else begin
                        ctrl_next[n][CR_EN] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        low_set  = '0;
        high_set = '0;
        for (int n = 0; n < NUM_STREAMS; n++) begin
            if (tc_set[n]) begin
                if (n < STREAMS_PER_REG)
                    low_set = low_set | (32'(1) << (dsc_flag_shift(2'(n)) + 5'(FL_TCIF)));
                else
                    high_set = high_set | (32'(1) << (dsc_flag_shift(2'(n)) + 5'(FL_TCIF)));
            end
        end
        low_next  = ((is_wr && dec.is_lifcr) ? (low_reg & ~req.wdata) : low_reg) | low_set;
        high_next = ((is_wr && dec.is_hifcr) ? (high_reg & ~req.wdata) : high_reg) | high_set;
    end

    always_comb begin
        logic [5:0] fl;
        for (int n = 0; n < NUM_STREAMS; n++) begin
            if (n < STREAMS_PER_REG) begin
                refresh[n] = (is_wr && dec.is_lifcr) || tc_set[n];
                fl = 6'(low_next >> dsc_flag_shift(2'(n))) & FLAG_MASK;
            end else begin
                refresh[n] = (is_wr && dec.is_hifcr) || tc_set[n];
                fl = 6'(high_next >> dsc_flag_shift(2'(n))) & FLAG_MASK;
            end
            irq_next[n] = refresh[n] ? dsc_irq_up(fl, ctrl_next[n]) : irq_reg[n];
        end
    end

    // result fields
    always_comb begin
        logic m2p;
        res = '0;
        m2p = (req.wdata[CR_DIR_LSB+:2] == DIR_M2P);
        if (is_rd) begin
            if (dec.is_lisr) begin
                res.read_data = low_reg;
            end else if (dec.is_hisr) begin
                res.read_data = high_reg;
            end else if (dec.stream_hit) begin
                case (dec.reg_sel)
                    REG_CR:   res.read_data = ctrl_reg[idx];
                    REG_NDTR: res.read_data = {16'h0000, cnt_reg[idx]};
                    REG_PAR:  res.read_data = par_reg[idx];
                    REG_M0AR: res.read_data = m0_reg[idx];
                    REG_M1AR: res.read_data = m1_reg[idx];
                    REG_FCR:  res.read_data = fcr_reg[idx];
                    default:  res.read_data = '0;
                endcase
            end
        end
        if (|grant) begin
            res.byte_taken      = 1'b1;
            res.mem_write_valid = 1'b1;
            res.mem_write_byte  = req.bval;
            for (int n = 0; n < NUM_STREAMS; n++)
                res.mem_write_addr = res.mem_write_addr | (grant[n] ? lane_addr[n] : '0);
        end
        if (|copy_set) begin
            res.copy_valid   = 1'b1;
            res.copy_src     = m2p ? m0_reg[idx] : par_reg[idx];
            res.copy_dst     = m2p ? par_reg[idx] : m0_reg[idx];
            res.copy_count   = cnt_reg[idx];
            res.copy_src_inc = m2p ? req.wdata[CR_MINC] : req.wdata[CR_PINC];
            res.copy_dst_inc = m2p ? req.wdata[CR_PINC] : req.wdata[CR_MINC];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
            irq_reg  <= '0;
            for (int n = 0; n < NUM_STREAMS; n++) begin
                ctrl_reg[n]  <= '0;
                cnt_reg[n]   <= '0;
                start_reg[n] <= '0;
                par_reg[n]   <= '0;
                m0_reg[n]    <= '0;
                m1_reg[n]    <= '0;
                fcr_reg[n]   <= FCR_RESET;
            end
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
            irq_reg  <= irq_next;
            for (int n = 0; n < NUM_STREAMS; n++) begin
                ctrl_reg[n]  <= ctrl_next[n];
                cnt_reg[n]   <= cnt_next[n];
                start_reg[n] <= start_next[n];
                par_reg[n]   <= par_next[n];
                m0_reg[n]    <= m0_next[n];
                m1_reg[n]    <= m1_next[n];
                fcr_reg[n]   <= fcr_next[n];
            end
        end
    end

    `DSC_ASSERT(a_grant_single, aclk, aresetn, $onehot0(grant))
    `DSC_ASSERT(a_grant_byte_only, aclk, aresetn, (grant != '0) |-> is_byte)
    `DSC_ASSERT(a_copy_from_write, aclk, aresetn, res.copy_valid |-> (is_wr && dec.stream_hit && !res.mem_write_valid))
    `DSC_ASSERT_NEXT(a_irq_hold, aclk, aresetn, adv && (refresh == '0), $stable(irq_reg))

endmodule

@@ hdl/dma_stream_controller_core.sv @@
// Top level of the eight-stream DMA controller: request and result registers
// A request waits in the request register and moves to the result register when it advances.
// One request per cycle unless the result side stalls; one more enters while a result waits.
// The single pass through the stream lanes and claim priority sets the cycle.
// Reset (aresetn low, synchronous) clears the register map, FIFO control to 0x21, and both stages.
`timescale 1ns / 1ps
module dma_stream_controller_core
    import dsc_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [9:0]             s_bus_offset,
    input  logic [31:0]            s_write_data,
    input  logic [31:0]            s_periph_addr,
    input  logic [7:0]             s_byte_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_read_data,
    output logic                   m_byte_taken,
    output logic                   m_mem_write_valid,
    output logic [31:0]            m_mem_write_addr,
    output logic [7:0]             m_mem_write_byte,
    output logic                   m_copy_valid,
    output logic [31:0]            m_copy_src,
    output logic [31:0]            m_copy_dst,
    output logic [15:0]            m_copy_count,
    output logic                   m_copy_src_inc,
    output logic                   m_copy_dst_inc,
    output logic [NUM_STREAMS-1:0] m_irq_lines
);

    localparam int IDX_W = $clog2(NUM_STREAMS);

    logic                   in_valid_reg;
    dsc_req_t               req_reg;
    logic [9:0]             offset_reg;
    logic                   out_valid_reg;
    dsc_result_t            res_reg;
    logic [NUM_STREAMS-1:0] irq_reg;

    logic                   adv;
    dsc_dec_t               dec;
    logic [IDX_W-1:0]       idx;
    dsc_result_t            res;
    logic [NUM_STREAMS-1:0] irq_next;

    // request moves on when the result register is free or being drained
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    dsc_decode #(
        .NUM_STREAMS(NUM_STREAMS)
    ) u_decode (
        .offset(offset_reg),
        .dec   (dec),
        .idx   (idx)
    );

    dsc_core #(
        .NUM_STREAMS(NUM_STREAMS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .req     (req_reg),
        .dec     (dec),
        .idx     (idx),
        .res     (res),
        .irq_next(irq_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.kind  <= s_req_type;
            req_reg.wdata <= s_write_data;
            req_reg.paddr <= s_periph_addr;
            req_reg.bval  <= s_byte_value;
            offset_reg    <= s_bus_offset;
        end
        if (adv) begin
            res_reg <= res;
            irq_reg <= irq_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_read_data       = res_reg.read_data;
    assign m_byte_taken      = res_reg.byte_taken;
    assign m_mem_write_valid = res_reg.mem_write_valid;
    assign m_mem_write_addr  = res_reg.mem_write_addr;
    assign m_mem_write_byte  = res_reg.mem_write_byte;
    assign m_copy_valid      = res_reg.copy_valid;
    assign m_copy_src        = res_reg.copy_src;
    assign m_copy_dst        = res_reg.copy_dst;
    assign m_copy_count      = res_reg.copy_count;
    assign m_copy_src_inc    = res_reg.copy_src_inc;
    assign m_copy_dst_inc    = res_reg.copy_dst_inc;
    assign m_irq_lines       = irq_reg;

endmodule

@@ bench/dsc_result_check.sv @@
// Result checker for dma_stream_controller_core: tracks register state, predicts and compares
`timescale 1ns / 1ps
module dsc_result_check
    import dsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [9:0]  s_bus_offset,
    input  logic [31:0] s_write_data,
    input  logic [31:0] s_periph_addr,
    input  logic [7:0]  s_byte_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_read_data,
    input  logic        m_byte_taken,
    input  logic        m_mem_write_valid,
    input  logic [31:0] m_mem_write_addr,
    input  logic [7:0]  m_mem_write_byte,
    input  logic        m_copy_valid,
    input  logic [31:0] m_copy_src,
    input  logic [31:0] m_copy_dst,
    input  logic [15:0] m_copy_count,
    input  logic        m_copy_src_inc,
    input  logic        m_copy_dst_inc,
    input  logic [7:0]  m_irq_lines,
    output int          fail_count,
    output int          open_count
);
    localparam int NSTR = NUM_STREAMS_DEF;

    typedef struct packed {
        logic [31:0] rdata;
        logic        taken;
        logic        wr_v;
        logic [31:0] wr_addr;
        logic [7:0]  wr_byte;
        logic        cp_v;
        logic [31:0] cp_src;
        logic [31:0] cp_dst;
        logic [15:0] cp_cnt;
        logic        cp_sinc;
        logic        cp_dinc;
        logic [7:0]  irq;
    } outcome_t;

    logic [31:0] stat_lo;
    logic [31:0] stat_hi;
    logic [31:0] ctl       [NSTR];
    logic [15:0] cnt       [NSTR];
    logic [15:0] cnt_start [NSTR];
    logic [31:0] per_addr  [NSTR];
    logic [31:0] buf0      [NSTR];
    logic [31:0] buf1      [NSTR];
    logic [31:0] fifo_ctl  [NSTR];
    logic [7:0]  irq_now;

    outcome_t pred;
    outcome_t want;
    outcome_t queued_results[$];
    int errs = 0;

    task automatic clear_state();
        int n;
        stat_lo = '0;
        stat_hi = '0;
        irq_now = '0;
        for (n = 0; n < NSTR; n++) begin
            ctl[n] = '0;
            cnt[n] = '0;
            cnt_start[n] = '0;
            per_addr[n] = '0;
            buf0[n] = '0;
            buf1[n] = '0;
            fifo_ctl[n] = FCR_RESET;
        end
    endtask

    // flag group of stream n sits at 0, 6, 16 or 22
    function automatic int group_pos(input int n);
        return (((n & 2) != 0) ? 16 : 0) + (((n & 1) != 0) ? 6 : 0);
    endfunction

    function automatic logic decode_stream(input logic [9:0] off, output int n,
                                           output dsc_reg_e r);
        int rel;
        n = 0;
        r = REG_CR;
        if (off < STREAM_BASE || off >= STREAM_BASE + STREAM_STRIDE * NSTR)
            return 1'b0;
        rel = int'(off) - STREAM_BASE;
        n = rel / STREAM_STRIDE;
        rel = rel % STREAM_STRIDE;
        if (rel % 4 != 0)
            return 1'b0;
        r = dsc_reg_e'(3'(rel / 4));
        return 1'b1;
    endfunction

    task automatic mark_done(input int n);
        if (n < 4)
            stat_lo[group_pos(n) + FL_TCIF] = 1'b1;
        else
            stat_hi[group_pos(n) + FL_TCIF] = 1'b1;
    endtask

    task automatic refresh_level(input int n);
        logic [31:0] st;
        logic [5:0]  fl;
        logic [31:0] c;
        st = (n < 4) ? stat_lo : stat_hi;
        fl = st[group_pos(n) +: 6];
        c = ctl[n];
        irq_now[n] = (c[CR_TCIE] & fl[FL_TCIF]) | (c[CR_HTIE] & fl[FL_HTIF]) |
                     (c[CR_TEIE] & fl[FL_TEIF]) | (c[CR_DMEIE] & fl[FL_DMEIF]);
    endtask

    function automatic logic [31:0] read_reg(input logic [9:0] off);
        int n;
        dsc_reg_e r;
        if (off == OFF_LISR) return stat_lo;
        if (off == OFF_HISR) return stat_hi;
        if (!decode_stream(off, n, r)) return '0;
        case (r)
            REG_CR:   return ctl[n];
            REG_NDTR: return {16'h0, cnt[n]};
            REG_PAR:  return per_addr[n];
            REG_M0AR: return buf0[n];
            REG_M1AR: return buf1[n];
            REG_FCR:  return fifo_ctl[n];
            default:  return '0;
        endcase
    endfunction

    // normal-mode enable: whole block goes out as one copy and completes at once
    task automatic start_copy(input int n);
        logic [31:0] c;
        c = ctl[n];
        if (cnt[n] != 0) begin
            pred.cp_v = 1'b1;
            if (c[CR_DIR_LSB +: 2] == DIR_M2P) begin
                pred.cp_src  = buf0[n];
                pred.cp_dst  = per_addr[n];
                pred.cp_sinc = c[CR_MINC];
                pred.cp_dinc = c[CR_PINC];
            end else begin
                pred.cp_src  = per_addr[n];
                pred.cp_dst  = buf0[n];
                pred.cp_sinc = c[CR_PINC];
                pred.cp_dinc = c[CR_MINC];
            end
            pred.cp_cnt = cnt[n];
            mark_done(n);
            ctl[n][CR_EN] = 1'b0;
            cnt[n] = '0;
            refresh_level(n);
        end
    endtask

    task automatic write_reg(input logic [9:0] off, input logic [31:0] wd);
        int n;
        dsc_reg_e r;
        logic was_on;
        if (off == OFF_LIFCR) begin
            stat_lo &= ~wd;
            for (n = 0; n < 4; n++) refresh_level(n);
        end else if (off == OFF_HIFCR) begin
            stat_hi &= ~wd;
            for (n = 4; n < NSTR; n++) refresh_level(n);
        end else if (decode_stream(off, n, r)) begin
            case (r)
                REG_CR: begin
                    was_on = ctl[n][CR_EN];
                    ctl[n] = wd;
                    if (!was_on && wd[CR_EN]) begin
                        cnt_start[n] = cnt[n];
                        if (!wd[CR_CIRC] && !wd[CR_DBM])
                            start_copy(n);
                    end
                end
                REG_NDTR: cnt[n] = wd[15:0];
                REG_PAR:  per_addr[n] = wd;
                REG_M0AR: buf0[n] = wd;
                REG_M1AR: buf1[n] = wd;
                REG_FCR:  fifo_ctl[n] = wd;
                default: ;
            endcase
        end
    endtask

    task automatic claim_byte(input logic [31:0] pa, input logic [7:0] bv);
        int n;
        logic [31:0] cur;
        logic [31:0] base;
        logic hit;
        hit = 1'b0;
        for (n = 0; n < NSTR; n++) begin
            cur = ctl[n];
            if (!hit && cur[CR_EN] && cur[CR_DIR_LSB +: 2] == DIR_P2M &&
                per_addr[n] == pa && cnt[n] != 0) begin
                hit = 1'b1;
                base = (cur[CR_DBM] && cur[CR_CT]) ? buf1[n] : buf0[n];
                pred.taken   = 1'b1;
                pred.wr_v    = 1'b1;
                // bytes done wraps when the count was rewritten above the start count
                pred.wr_addr = base + ({16'h0, cnt_start[n]} - {16'h0, cnt[n]});
                pred.wr_byte = bv;
                cnt[n] = cnt[n] - 16'd1;
                if (cnt[n] == 0) begin
                    mark_done(n);
                    if (cur[CR_DBM]) begin
                        ctl[n][CR_CT] = ~ctl[n][CR_CT];
                        cnt[n] = cnt_start[n];
                    end else if (cur[CR_CIRC]) begin
                        cnt[n] = cnt_start[n];
                    end else begin
                        ctl[n][CR_EN] = 1'b0;
                    end
                    refresh_level(n);
                end
            end
        end
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [9:0] off,
                                   input logic [31:0] wd, input logic [31:0] pa,
                                   input logic [7:0] bv);
        pred = '0;
        case (kind)
            REQ_READ:  pred.rdata = read_reg(off);
            REQ_WRITE: write_reg(off, wd);
            REQ_BYTE:  claim_byte(pa, bv);
            default: ;
        endcase
        pred.irq = irq_now;
    endtask

    task automatic compare_field(input string tag, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            if (errs < 10)
                $display("mismatch on %s: expected %h, got %h", tag, exp_v, got_v);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            queued_results.delete();
        end else begin
            // retire results first so a result cannot match a request taken at the same edge
            if (m_valid && m_ready) begin
                if (queued_results.size() == 0) begin
                    if (errs < 10)
                        $display("result arrived with no request outstanding");
                    errs++;
                end else begin
                    want = queued_results.pop_front();
                    compare_field("read_data", want.rdata, m_read_data);
                    compare_field("byte_taken", 32'(want.taken), 32'(m_byte_taken));
                    compare_field("mem_write_valid", 32'(want.wr_v), 32'(m_mem_write_valid));
                    compare_field("mem_write_addr", want.wr_addr, m_mem_write_addr);
                    compare_field("mem_write_byte", 32'(want.wr_byte), 32'(m_mem_write_byte));
                    compare_field("copy_valid", 32'(want.cp_v), 32'(m_copy_valid));
                    compare_field("copy_src", want.cp_src, m_copy_src);
                    compare_field("copy_dst", want.cp_dst, m_copy_dst);
                    compare_field("copy_count", 32'(want.cp_cnt), 32'(m_copy_count));
                    compare_field("copy_src_inc", 32'(want.cp_sinc), 32'(m_copy_src_inc));
                    compare_field("copy_dst_inc", 32'(want.cp_dinc), 32'(m_copy_dst_inc));
                    compare_field("irq_lines", 32'(want.irq), 32'(m_irq_lines));
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_req_type, s_bus_offset, s_write_data, s_periph_addr,
                                s_byte_value);
                queued_results.push_back(pred);
            end
        end
        fail_count <= errs;
        open_count <= queued_results.size();
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for dma_stream_controller_core: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb;
    import dsc_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [1:0] DIR_M2M  = 2'b10;
    localparam logic [1:0] DIR_RSVD = 2'b11;

    localparam logic [31:0] EN_M    = 32'h1 << CR_EN;
    localparam logic [31:0] DMEIE_M = 32'h1 << CR_DMEIE;
    localparam logic [31:0] TCIE_M  = 32'h1 << CR_TCIE;
    localparam logic [31:0] CIRC_M  = 32'h1 << CR_CIRC;
    localparam logic [31:0] PINC_M  = 32'h1 << CR_PINC;
    localparam logic [31:0] MINC_M  = 32'h1 << CR_MINC;
    localparam logic [31:0] DBM_M   = 32'h1 << CR_DBM;
    localparam logic [31:0] CT_M    = 32'h1 << CR_CT;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_READ;
    logic [9:0]  s_bus_offset = '0;
    logic [31:0] s_write_data = '0;
    logic [31:0] s_periph_addr = '0;
    logic [7:0]  s_byte_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_byte_taken;
    logic        m_mem_write_valid;
    logic [31:0] m_mem_write_addr;
    logic [7:0]  m_mem_write_byte;
    logic        m_copy_valid;
    logic [31:0] m_copy_src;
    logic [31:0] m_copy_dst;
    logic [15:0] m_copy_count;
    logic        m_copy_src_inc;
    logic        m_copy_dst_inc;
    logic [7:0]  m_irq_lines;

    int fails;
    int pending;

    always #6 aclk = ~aclk;

    dma_stream_controller_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_bus_offset      (s_bus_offset),
        .s_write_data      (s_write_data),
        .s_periph_addr     (s_periph_addr),
        .s_byte_value      (s_byte_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_byte_taken      (m_byte_taken),
        .m_mem_write_valid (m_mem_write_valid),
        .m_mem_write_addr  (m_mem_write_addr),
        .m_mem_write_byte  (m_mem_write_byte),
        .m_copy_valid      (m_copy_valid),
        .m_copy_src        (m_copy_src),
        .m_copy_dst        (m_copy_dst),
        .m_copy_count      (m_copy_count),
        .m_copy_src_inc    (m_copy_src_inc),
        .m_copy_dst_inc    (m_copy_dst_inc),
        .m_irq_lines       (m_irq_lines)
    );

    dsc_result_check checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_bus_offset      (s_bus_offset),
        .s_write_data      (s_write_data),
        .s_periph_addr     (s_periph_addr),
        .s_byte_value      (s_byte_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_byte_taken      (m_byte_taken),
        .m_mem_write_valid (m_mem_write_valid),
        .m_mem_write_addr  (m_mem_write_addr),
        .m_mem_write_byte  (m_mem_write_byte),
        .m_copy_valid      (m_copy_valid),
        .m_copy_src        (m_copy_src),
        .m_copy_dst        (m_copy_dst),
        .m_copy_count      (m_copy_count),
        .m_copy_src_inc    (m_copy_src_inc),
        .m_copy_dst_inc    (m_copy_dst_inc),
        .m_irq_lines       (m_irq_lines),
        .fail_count        (fails),
        .open_count        (pending)
    );

    // result side: stall mode is redrawn at random whenever its run ends
    logic [1:0] stall_mode = 2'd0;
    int         mode_left = 0;
    logic [7:0] ready_pat = 8'hFF;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 200);
            ready_pat <= 8'($urandom()) | 8'h01;
        end else begin
            mode_left <= mode_left - 1;
            ready_pat <= {ready_pat[0], ready_pat[7:1]};
        end
        case (stall_mode)
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= 1'($urandom_range(0, 1));
            2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ready_pat[0];
        endcase
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("dma_stream_controller_core test failed");
        $finish;
    end

    int          sent = 0;
    int          burst_left = 4;
    logic        drive_on = 1'b0;
    logic [31:0] src_pool [4];

    function automatic logic [9:0] reg_off(input int n, input dsc_reg_e r);
        return 10'(STREAM_BASE + STREAM_STRIDE * n + 4 * int'(r));
    endfunction

    // hold one request until it is taken; bursts end with a gap in which s_valid is low
    task automatic send_request(input logic [1:0] kind, input logic [9:0] off,
                                input logic [31:0] data, input logic [31:0] pa,
                                input logic [7:0] bv);
        s_req_type    <= kind;
        s_bus_offset  <= off;
        s_write_data  <= data;
        s_periph_addr <= pa;
        s_byte_value  <= bv;
        s_valid       <= 1'b1;
        drive_on = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (kind != REQ_NONE) sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            drive_on = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
        end
    endtask

    task automatic bus_wr(input logic [9:0] off, input logic [31:0] data);
        send_request(REQ_WRITE, off, data, $urandom(), 8'($urandom()));
    endtask

    task automatic bus_rd(input logic [9:0] off);
        send_request(REQ_READ, off, $urandom(), $urandom(), 8'($urandom()));
    endtask

    task automatic push_byte(input logic [31:0] pa, input logic [7:0] bv);
        send_request(REQ_BYTE, 10'($urandom()), $urandom(), pa, bv);
    endtask

    task automatic setup_stream();
        int          n;
        int          pick;
        logic [15:0] len;
        logic [31:0] c;
        n = $urandom_range(0, 7);
        // usually start from a disabled stream so the enable path is taken
        if ($urandom_range(0, 3) != 0) bus_wr(reg_off(n, REG_CR), 32'h0);
        bus_wr(reg_off(n, REG_PAR), src_pool[$urandom_range(0, 3)]);
        bus_wr(reg_off(n, REG_M0AR), $urandom());
        if ($urandom_range(0, 1)) bus_wr(reg_off(n, REG_M1AR), $urandom());
        pick = $urandom_range(0, 9);
        len = (pick == 0) ? 16'h0 : (pick == 1) ? 16'($urandom()) : 16'($urandom_range(1, 6));
        bus_wr(reg_off(n, REG_NDTR), {16'($urandom()), len});
        c = $urandom();
        c[CR_EN] = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 9);
        case (pick)
            7:       c[CR_DIR_LSB +: 2] = DIR_M2P;
            8:       c[CR_DIR_LSB +: 2] = DIR_M2M;
            9:       c[CR_DIR_LSB +: 2] = DIR_RSVD;
            default: c[CR_DIR_LSB +: 2] = DIR_P2M;
        endcase
        pick = $urandom_range(0, 9);
        c[CR_CIRC] = (pick < 4);
        c[CR_DBM]  = (pick >= 4 && pick < 7);
        bus_wr(reg_off(n, REG_CR), c);
    endtask

    task automatic byte_burst();
        int k;
        int len;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
            push_byte(($urandom_range(0, 6) != 0) ? src_pool[$urandom_range(0, 3)]
                                                  : $urandom(), 8'($urandom()));
    endtask

    task automatic poke_and_read();
        int       n;
        dsc_reg_e r;
        n = $urandom_range(0, 7);
        r = dsc_reg_e'(3'($urandom_range(0, NUM_STREAM_REGS - 1)));
        if ($urandom_range(0, 3) == 0) begin
            bus_rd(($urandom_range(0, 1)) ? OFF_LISR : OFF_HISR);
        end else begin
            if ((r == REG_FCR || r == REG_M1AR) && $urandom_range(0, 1))
                bus_wr(reg_off(n, r), $urandom());
            bus_rd(reg_off(n, r));
        end
    endtask

    int pick;
    int target;

    initial begin
        src_pool[0] = 32'h0;
        src_pool[1] = 32'hFFFF_FFFF;
        src_pool[2] = $urandom();
        src_pool[3] = $urandom();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset values, ignored and malformed accesses
        bus_rd(reg_off(7, REG_FCR));
        bus_wr(OFF_LISR, 32'hFFFF_FFFF);
        send_request(REQ_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        bus_rd(10'h011);
        bus_wr(10'h3FF, 32'hFFFF_FFFF);
        // full-size memory-to-peripheral block copy, then flag clear
        bus_wr(reg_off(1, REG_M0AR), 32'hFFFF_FFFF);
        bus_wr(reg_off(1, REG_NDTR), 32'h0000_FFFF);
        bus_wr(reg_off(1, REG_CR), EN_M | (32'(DIR_M2P) << CR_DIR_LSB) | PINC_M | MINC_M | TCIE_M);
        bus_wr(OFF_LIFCR, 32'hFFFF_FFFF);
        // circular stream, address runs up to 0xFFFF_FFFF and the count reloads
        bus_wr(reg_off(0, REG_M0AR), 32'hFFFF_FFFE);
        bus_wr(reg_off(0, REG_NDTR), 32'h2);
        bus_wr(reg_off(0, REG_CR), EN_M | CIRC_M | MINC_M | TCIE_M);
        push_byte(32'h0, 8'hFF);
        push_byte(32'h0, 8'h00);
        push_byte(32'h0, 8'hA5);
        // double buffer starting on buffer 1
        bus_wr(reg_off(7, REG_NDTR), 32'h1);
        bus_wr(reg_off(7, REG_M1AR), 32'h8000_0000);
        bus_wr(reg_off(7, REG_CR), EN_M | DBM_M | CT_M | TCIE_M | DMEIE_M);
        bus_wr(reg_off(0, REG_CR), 32'h0);
        push_byte(32'h0, 8'h5A);
        push_byte(32'h0, 8'hC3);
        bus_wr(OFF_HIFCR, 32'hFFFF_FFFF);
        // enable with zero count, then count written while enabled
        bus_wr(reg_off(2, REG_CR), EN_M);
        bus_wr(reg_off(2, REG_NDTR), 32'h3);
        push_byte(32'h0, 8'h81);
        // reserved direction copies like peripheral-to-memory
        bus_wr(reg_off(3, REG_NDTR), 32'h5);
        bus_wr(reg_off(3, REG_CR), EN_M | (32'(DIR_RSVD) << CR_DIR_LSB) | PINC_M);
        // control write with enable already set only stores
        bus_wr(reg_off(2, REG_CR), EN_M | CIRC_M | TCIE_M);

        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
                setup_stream();
            else if (pick < 68)
                byte_burst();
            else if (pick < 80)
                poke_and_read();
            else if (pick < 88)
                bus_wr(($urandom_range(0, 1)) ? OFF_LIFCR : OFF_HIFCR,
                       ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom());
            else if (pick < 94)
                bus_wr(reg_off($urandom_range(0, 7), REG_NDTR),
                       {16'($urandom()), 16'($urandom_range(0, 9))});
            else
                send_request(2'($urandom()), 10'($urandom()), $urandom(), $urandom(),
                             8'($urandom()));
        end
        if (drive_on) s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && pending == 0)
            $display("dma_stream_controller_core test passed");
        else
            $display("dma_stream_controller_core test failed");
        $finish;
    end

endmodule
